/* rtl/assert_macros.svh */
// Assertion macros for arrive_steering_core, the RTL file of the arrive steering block that includes them.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define AS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset disables the check.
`define AS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/as_pkg.sv */
// Package for the arrive steering block: band codes, register indexes and fixed widths.
// No dependencies; arrive_steering_core imports it.
`timescale 1ns / 1ps

package as_pkg;

   // Width of each configuration register, unsigned fixed point.
   localparam int CFG_W = 31;
   // Width of the square root result (radicand is twice as wide).
   localparam int RT_W = 32;
   // Configuration bus widths.
   localparam int PADDR_W = 5;
   localparam int PDATA_W = 32;

   // Band reported with each result.
   typedef enum logic [1:0] {
      BAND_FULL    = 2'd0,
      BAND_RAMP    = 2'd1,
      BAND_ARRIVED = 2'd2
   } band_type;

   // Register indexes (word address).
   localparam logic [2:0] REG_SLOW_RADIUS    = 3'd0;
   localparam logic [2:0] REG_STOP_RADIUS    = 3'd1;
   localparam logic [2:0] REG_MAX_ACCEL      = 3'd2;
   localparam logic [2:0] REG_MAX_SPEED      = 3'd3;
   localparam logic [2:0] REG_TIME_TO_TARGET = 3'd4;

   // Register reset values.
   localparam logic [CFG_W-1:0] RST_SLOW_RADIUS    = 31'd6553600;
   localparam logic [CFG_W-1:0] RST_STOP_RADIUS    = 31'd655360;
   localparam logic [CFG_W-1:0] RST_MAX_ACCEL      = 31'd655360;
   localparam logic [CFG_W-1:0] RST_MAX_SPEED      = 31'd655360;
   localparam logic [CFG_W-1:0] RST_TIME_TO_TARGET = 31'd65536;

endpackage

/* rtl/as_ifs.sv */
// Request and response channel interfaces of the arrive steering block.
// Depends on nothing; used by arrive_steering_core.
`timescale 1ns / 1ps

interface as_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] self_x;
   logic signed [DATA_WIDTH-1:0] self_y;
   logic signed [DATA_WIDTH-1:0] vel_x;
   logic signed [DATA_WIDTH-1:0] vel_y;
   logic signed [DATA_WIDTH-1:0] goal_x;
   logic signed [DATA_WIDTH-1:0] goal_y;

   modport source (output valid, self_x, self_y, vel_x, vel_y, goal_x, goal_y, input ready);
   modport sink (input valid, self_x, self_y, vel_x, vel_y, goal_x, goal_y, output ready);
endinterface

interface as_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] accel_x;
   logic signed [DATA_WIDTH-1:0] accel_y;
   logic [1:0]                   band;
   logic                         saturated;

   modport source (output valid, accel_x, accel_y, band, saturated, input ready);
   modport sink (input valid, accel_x, accel_y, band, saturated, output ready);
endinterface

/* rtl/as_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with a sideband that travels along.
// Depends on nothing; used by arrive_steering_core.
`timescale 1ns / 1ps

module as_sqrt #(
   parameter int RT_W   = 32,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [2*RT_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [RT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int REM_W = RT_W + 2;

   logic                vld_ff  [0:RT_W];
   logic [REM_W-1:0]    rem_ff  [0:RT_W];
   logic [RT_W-1:0]     root_ff [0:RT_W];
   logic [2*RT_W-1:0]   rad_ff  [0:RT_W];
   logic [SIDE_W-1:0]   side_ff [0:RT_W];

   // Entry stage loads the radicand.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         rad_ff[0]  <= in_rad;
         side_ff[0] <= in_side;
      end
   end

   // Each stage brings down two radicand bits and decides one root bit.
   for (genvar k = 0; k < RT_W; k++) begin : g_step
      logic [REM_W-1:0]  rem_in;
      logic [RT_W-1:0]   root_in;
      logic [REM_W-1:0]  rem_pair;
      logic [REM_W-1:0]  trial;

      always_comb begin
         rem_pair = {rem_ff[k][RT_W-1:0], rad_ff[k][2*RT_W-1 -: 2]};
         trial    = {root_ff[k], 2'b01};
         if (rem_pair >= trial) begin
            rem_in  = rem_pair - trial;
            root_in = {root_ff[k][RT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_pair;
            root_in = {root_ff[k][RT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            rad_ff[k+1]  <= {rad_ff[k][2*RT_W-3:0], 2'b00};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[RT_W];
   assign out_root  = root_ff[RT_W];
   assign out_side  = side_ff[RT_W];

endmodule

/* rtl/as_div.sv */
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing one divisor.
// Depends on nothing; used by arrive_steering_core. The quotient must fit in QUO_W bits.
`timescale 1ns / 1ps

module as_div #(
   parameter int NUM_W  = 62,
   parameter int DEN_W  = 31,
   parameter int QUO_W  = 31,
   parameter int LANES  = 1,
   parameter int SIDE_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]   in_num,
   input  logic [DEN_W-1:0]              in_den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][QUO_W-1:0]   out_quo,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int HI_W  = NUM_W - QUO_W;
   localparam int REM_W = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;

   logic                          vld_ff  [0:QUO_W];
   logic [DEN_W-1:0]              den_ff  [0:QUO_W];
   logic [SIDE_W-1:0]             side_ff [0:QUO_W];
   logic [LANES-1:0][REM_W-1:0]   rem_ff  [0:QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   sh_ff   [0:QUO_W];

   // Entry stage: upper numerator bits seed the remainder, lower bits wait in the shifter.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= REM_W'(in_num[l][NUM_W-1:QUO_W]);
            sh_ff[0][l]  <= in_num[l][QUO_W-1:0];
         end
      end
   end

   // Each stage shifts in one numerator bit and produces one quotient bit.
   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [LANES-1:0][REM_W-1:0] rem_in;
      logic [LANES-1:0][QUO_W-1:0] sh_in;

      always_comb begin
         logic [REM_W-1:0] rem_sh;
         logic [REM_W-1:0] den_ext;
         logic             ge;
         den_ext = REM_W'(den_ff[k]);
         for (int l = 0; l < LANES; l++) begin
            rem_sh    = {rem_ff[k][l][REM_W-2:0], sh_ff[k][l][QUO_W-1]};
            ge        = (rem_sh >= den_ext);
            rem_in[l] = ge ? (rem_sh - den_ext) : rem_sh;
            sh_in[l]  = {sh_ff[k][l][QUO_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
            rem_ff[k+1]  <= rem_in;
            sh_ff[k+1]   <= sh_in;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out_quo   = sh_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

/* rtl/as_out_buf.sv */
// Output register with a skid stage; holds the pipeline only when both are full.
// Depends on nothing; used by arrive_steering_core.
`timescale 1ns / 1ps

module as_out_buf #(
   parameter int W = 67
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [W-1:0] in_data,
   output logic         en,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   logic         out_vld_ff, out_vld_in;
   logic         skid_vld_ff, skid_vld_in;
   logic [W-1:0] out_dat_ff, out_dat_in;
   logic [W-1:0] skid_dat_ff, skid_dat_in;
   logic         fire;

   assign en   = !skid_vld_ff;
   assign fire = in_valid && en;

   // Refill the output from the skid first, else from the pipeline.
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_dat_in  = out_dat_ff;
      skid_vld_in = skid_vld_ff;
      skid_dat_in = skid_dat_ff;
      if (!out_vld_ff || out_ready) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_dat_in  = skid_dat_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in = fire;
            out_dat_in = in_data;
         end
      end else if (fire) begin
         skid_vld_in = 1'b1;
         skid_dat_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_dat_ff  <= out_dat_in;
      skid_dat_ff <= skid_dat_in;
   end

   assign out_valid = out_vld_ff;
   assign out_data  = out_dat_ff;

endmodule

/* rtl/arrive_steering_core.sv */
// Arrive steering core: one agent request per cycle, fully pipelined, no state kept between
// requests. It has RT_W + 2*CFG_W + DATA_WIDTH + 11 register stages (137 at the defaults),
// set by the bit-per-stage square root and the three chained bit-per-stage dividers (ramp
// speed, offset scaling, velocity-error over time). One result may wait at the output while
// the pipeline keeps taking requests; a second waiting result stalls the request side.
// Depends on as_pkg, as_ifs, as_sqrt, as_div, as_out_buf and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arrive_steering_core import as_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   as_req_if.sink              req_ch,
   as_rsp_if.source            rsp_ch,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]  prdata,
   output logic                pready
);

   localparam int DW   = DATA_WIDTH;
   localparam int CW   = CFG_W;
   localparam int MW   = DW + 1;
   localparam int MAXS = (MW > CW) ? (MW - CW) : 0;
   localparam int SW   = (MAXS > 0) ? $clog2(MAXS + 1) : 1;
   localparam int DSTW = RT_W + MAXS;
   localparam int DFW  = ((DW > CW + 1) ? DW : (CW + 1)) + 1;
   localparam int NCW  = DFW + FRAC_BITS;
   localparam int MAGW = ((DW > CW) ? DW : CW) + 1;
   localparam int OW   = 2 * DW + 3;
   localparam logic [MAGW-1:0] POS_MAX = {{(MAGW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};

   // Per-request information that rides along the pipeline.
   typedef struct packed {
      logic                  negx;
      logic                  negy;
      logic [CW-1:0]         sx;
      logic [CW-1:0]         sy;
      logic [SW-1:0]         s;
      logic [DW-1:0]         vx;
      logic [DW-1:0]         vy;
      band_type              band;
      logic [RT_W-1:0]       root;
      logic [CW-1:0]         qbx;
      logic [CW-1:0]         qby;
      logic                  dnegx;
      logic                  dnegy;
      logic                  ovfx;
      logic                  ovfy;
   } item_type;

   localparam int IW = $bits(item_type);

   // Saturate a sign and magnitude to a two's complement word; top bit flags clipping.
   function automatic logic [DW:0] sat_fn(input logic neg, input logic [MAGW-1:0] mag);
      logic          clip;
      logic [DW-1:0] val;
      clip = 1'b0;
      if (!neg) begin
         if (mag > POS_MAX) begin
            clip = 1'b1;
            val  = {1'b0, {(DW - 1){1'b1}}};
         end else begin
            val = DW'(mag);
         end
      end else begin
         if (mag > POS_MAX + 1'b1) begin
            clip = 1'b1;
            val  = {1'b1, {(DW - 1){1'b0}}};
         end else begin
            val = DW'(~mag + 1'b1);
         end
      end
      return {clip, val};
   endfunction

   logic pipe_en;

   // ---------------- Configuration registers ----------------
   logic [CW-1:0] slow_ff, stop_ff, maccel_ff, mspeed_ff, ttt_ff;
   logic [CW-1:0] tt;

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_ff   <= RST_SLOW_RADIUS;
         stop_ff   <= RST_STOP_RADIUS;
         maccel_ff <= RST_MAX_ACCEL;
         mspeed_ff <= RST_MAX_SPEED;
         ttt_ff    <= RST_TIME_TO_TARGET;
      end else if (psel && penable && pwrite) begin
         case (paddr[PADDR_W-1:2])
            REG_SLOW_RADIUS:    slow_ff   <= pwdata[CW-1:0];
            REG_STOP_RADIUS:    stop_ff   <= pwdata[CW-1:0];
            REG_MAX_ACCEL:      maccel_ff <= pwdata[CW-1:0];
            REG_MAX_SPEED:      mspeed_ff <= pwdata[CW-1:0];
            REG_TIME_TO_TARGET: ttt_ff    <= pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (paddr[PADDR_W-1:2])
         REG_SLOW_RADIUS:    prdata = PDATA_W'(slow_ff);
         REG_STOP_RADIUS:    prdata = PDATA_W'(stop_ff);
         REG_MAX_ACCEL:      prdata = PDATA_W'(maccel_ff);
         REG_MAX_SPEED:      prdata = PDATA_W'(mspeed_ff);
         REG_TIME_TO_TARGET: prdata = PDATA_W'(ttt_ff);
         default:            prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // A zero time to target counts as the smallest step.
   assign tt = (ttt_ff == '0) ? CW'(1) : ttt_ff;

   assign req_ch.ready = pipe_en;

   // ---------------- Stage 1: offset to the goal ----------------
   logic          p1_vld_ff;
   item_type      p1_item_ff, p1_item_in;
   logic [MW-1:0] p1_dx_ff, p1_dx_in, p1_dy_ff, p1_dy_in;

   always_comb begin
      p1_item_in    = '0;
      p1_item_in.vx = req_ch.vel_x;
      p1_item_in.vy = req_ch.vel_y;
      p1_dx_in = {req_ch.goal_x[DW-1], req_ch.goal_x} - {req_ch.self_x[DW-1], req_ch.self_x};
      p1_dy_in = {req_ch.goal_y[DW-1], req_ch.goal_y} - {req_ch.self_y[DW-1], req_ch.self_y};
   end

   // ---------------- Stage 2: magnitudes and range shift ----------------
   logic          p2_vld_ff;
   item_type      p2_item_ff, p2_item_in;

   always_comb begin
      logic [MW-1:0] ax;
      logic [MW-1:0] ay;
      logic [MW-1:0] m;
      logic [SW-1:0] s_v;
      ax = p1_dx_ff[MW-1] ? (~p1_dx_ff + 1'b1) : p1_dx_ff;
      ay = p1_dy_ff[MW-1] ? (~p1_dy_ff + 1'b1) : p1_dy_ff;
      m  = (ax > ay) ? ax : ay;
      // Smallest shift that brings the larger magnitude under the square root range.
      s_v = SW'(MAXS);
      for (int i = MAXS; i >= 0; i--) begin
         if (((m >> i) >> CW) == '0) begin
            s_v = SW'(i);
         end
      end
      p2_item_in      = p1_item_ff;
      p2_item_in.negx = p1_dx_ff[MW-1];
      p2_item_in.negy = p1_dy_ff[MW-1];
      p2_item_in.s    = s_v;
      p2_item_in.sx   = CW'(ax >> s_v);
      p2_item_in.sy   = CW'(ay >> s_v);
   end

   // ---------------- Stage 3: squares ----------------
   logic            p3_vld_ff;
   item_type        p3_item_ff;
   logic [2*CW-1:0] p3_sqx_ff, p3_sqx_in, p3_sqy_ff, p3_sqy_in;

   assign p3_sqx_in = (2*CW)'(p2_item_ff.sx) * (2*CW)'(p2_item_ff.sx);
   assign p3_sqy_in = (2*CW)'(p2_item_ff.sy) * (2*CW)'(p2_item_ff.sy);

   // ---------------- Stage 4: sum of squares ----------------
   logic              p4_vld_ff;
   item_type          p4_item_ff;
   logic [2*RT_W-1:0] p4_sum_ff, p4_sum_in;

   assign p4_sum_in = (2*RT_W)'(p3_sqx_ff) + (2*RT_W)'(p3_sqy_ff);

   // Front stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         p1_vld_ff <= req_ch.valid;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p1_item_ff <= p1_item_in;
         p1_dx_ff   <= p1_dx_in;
         p1_dy_ff   <= p1_dy_in;
         p2_item_ff <= p2_item_in;
         p3_item_ff <= p2_item_ff;
         p3_sqx_ff  <= p3_sqx_in;
         p3_sqy_ff  <= p3_sqy_in;
         p4_item_ff <= p3_item_ff;
         p4_sum_ff  <= p4_sum_in;
      end
   end

   // ---------------- Square root ----------------
   logic            sq_vld;
   logic [RT_W-1:0] sq_root;
   logic [IW-1:0]   sq_side;
   item_type        sq_item;

   as_sqrt #(.RT_W(RT_W), .SIDE_W(IW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (p4_vld_ff),
      .in_rad    (p4_sum_ff),
      .in_side   (p4_item_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign sq_item = item_type'(sq_side);

   // ---------------- Stage 5: distance and band ----------------
   logic          p5_vld_ff;
   item_type      p5_item_ff, p5_item_in;
   logic [CW-1:0] p5_dsub_ff, p5_dsub_in;

   always_comb begin
      logic [DSTW-1:0] dlen;
      dlen            = DSTW'(sq_root) << sq_item.s;
      p5_item_in      = sq_item;
      p5_item_in.root = sq_root;
      if (dlen > DSTW'(slow_ff)) begin
         p5_item_in.band = BAND_FULL;
      end else if (dlen > DSTW'(stop_ff)) begin
         p5_item_in.band = BAND_RAMP;
      end else begin
         p5_item_in.band = BAND_ARRIVED;
      end
      // In the ramp band the distance is below the slow radius and unshifted.
      p5_dsub_in = CW'(sq_root) - stop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         p5_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p5_item_ff <= p5_item_in;
         p5_dsub_ff <= p5_dsub_in;
      end
   end

   // ---------------- Divider A: ramp speed ----------------
   logic [0:0][2*CW-1:0] a_num;
   logic                 a_vld;
   logic [0:0][CW-1:0]   a_quo;
   logic [IW-1:0]        a_side;
   item_type             a_item;

   assign a_num[0] = (2*CW)'(mspeed_ff) * (2*CW)'(p5_dsub_ff);

   as_div #(.NUM_W(2*CW), .DEN_W(CW), .QUO_W(CW), .LANES(1), .SIDE_W(IW)) u_div_speed (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (p5_vld_ff),
      .in_num    (a_num),
      .in_den    (slow_ff - stop_ff),
      .in_side   (p5_item_ff),
      .out_valid (a_vld),
      .out_quo   (a_quo),
      .out_side  (a_side)
   );

   assign a_item = item_type'(a_side);

   // ---------------- Divider B: offset scaled to acceleration or speed ----------------
   logic [1:0][2*CW-1:0] b_num;
   logic [CW-1:0]        b_scale;
   logic                 b_vld;
   logic [1:0][CW-1:0]   b_quo;
   logic [IW-1:0]        b_side;
   item_type             b_item;

   assign b_scale  = (a_item.band == BAND_FULL) ? maccel_ff : a_quo[0];
   assign b_num[0] = (2*CW)'(a_item.sx) * (2*CW)'(b_scale);
   assign b_num[1] = (2*CW)'(a_item.sy) * (2*CW)'(b_scale);

   as_div #(.NUM_W(2*CW), .DEN_W(RT_W), .QUO_W(CW), .LANES(2), .SIDE_W(IW)) u_div_dir (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (a_vld),
      .in_num    (b_num),
      .in_den    (a_item.root),
      .in_side   (a_side),
      .out_valid (b_vld),
      .out_quo   (b_quo),
      .out_side  (b_side)
   );

   assign b_item = item_type'(b_side);

   // ---------------- Stage 8: velocity error ----------------
   logic           p8_vld_ff;
   item_type       p8_item_ff, p8_item_in;
   logic [DFW-1:0] p8_diffx_ff, p8_diffx_in, p8_diffy_ff, p8_diffy_in;

   always_comb begin
      logic [DFW-1:0] tx;
      logic [DFW-1:0] ty;
      tx = DFW'(b_quo[0]);
      ty = DFW'(b_quo[1]);
      if (b_item.negx) begin
         tx = ~tx + 1'b1;
      end
      if (b_item.negy) begin
         ty = ~ty + 1'b1;
      end
      p8_diffx_in    = tx - {{(DFW - DW){b_item.vx[DW-1]}}, b_item.vx};
      p8_diffy_in    = ty - {{(DFW - DW){b_item.vy[DW-1]}}, b_item.vy};
      p8_item_in     = b_item;
      p8_item_in.qbx = b_quo[0];
      p8_item_in.qby = b_quo[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p8_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         p8_vld_ff <= b_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p8_item_ff  <= p8_item_in;
         p8_diffx_ff <= p8_diffx_in;
         p8_diffy_ff <= p8_diffy_in;
      end
   end

   // ---------------- Divider C: error over time to target ----------------
   logic [1:0][NCW-1:0] c_num;
   item_type            c_in_item;
   logic                c_vld;
   logic [1:0][DW-1:0]  c_quo;
   logic [IW-1:0]       c_side;
   item_type            c_item;

   always_comb begin
      logic [DFW-1:0] magx;
      logic [DFW-1:0] magy;
      magx     = p8_diffx_ff[DFW-1] ? (~p8_diffx_ff + 1'b1) : p8_diffx_ff;
      magy     = p8_diffy_ff[DFW-1] ? (~p8_diffy_ff + 1'b1) : p8_diffy_ff;
      c_num[0] = {magx, {FRAC_BITS{1'b0}}};
      c_num[1] = {magy, {FRAC_BITS{1'b0}}};
      c_in_item       = p8_item_ff;
      c_in_item.dnegx = p8_diffx_ff[DFW-1];
      c_in_item.dnegy = p8_diffy_ff[DFW-1];
      // Quotient would not fit the output word: flag it and saturate later.
      c_in_item.ovfx  = ((c_num[0] >> DW) >= NCW'(tt));
      c_in_item.ovfy  = ((c_num[1] >> DW) >= NCW'(tt));
   end

   as_div #(.NUM_W(NCW), .DEN_W(CW), .QUO_W(DW), .LANES(2), .SIDE_W(IW)) u_div_time (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (p8_vld_ff),
      .in_num    (c_num),
      .in_den    (tt),
      .in_side   (c_in_item),
      .out_valid (c_vld),
      .out_quo   (c_quo),
      .out_side  (c_side)
   );

   assign c_item = item_type'(c_side);

   // ---------------- Result selection and saturation ----------------
   logic [DW:0]   res_x, res_y;
   logic [OW-1:0] res_data, out_data;

   always_comb begin
      case (c_item.band)
         BAND_FULL: begin
            res_x = sat_fn(c_item.negx, MAGW'(c_item.qbx));
            res_y = sat_fn(c_item.negy, MAGW'(c_item.qby));
         end
         BAND_RAMP: begin
            res_x = sat_fn(c_item.dnegx, c_item.ovfx ? '1 : MAGW'(c_quo[0]));
            res_y = sat_fn(c_item.dnegy, c_item.ovfy ? '1 : MAGW'(c_quo[1]));
         end
         default: begin
            res_x = '0;
            res_y = '0;
         end
      endcase
      res_data = {res_x[DW-1:0], res_y[DW-1:0], c_item.band, res_x[DW] | res_y[DW]};
   end

   as_out_buf #(.W(OW)) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld),
      .in_data   (res_data),
      .en        (pipe_en),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.accel_x   = out_data[OW-1 -: DW];
   assign rsp_ch.accel_y   = out_data[OW-DW-1 -: DW];
   assign rsp_ch.band      = out_data[2:1];
   assign rsp_ch.saturated = out_data[0];

   // ---------------- Assertions ----------------
   `AS_ASSERT_IMPL(a_arrived_is_zero, clock, reset, rsp_ch.valid && (rsp_ch.band == BAND_ARRIVED), (rsp_ch.accel_x == '0) && (rsp_ch.accel_y == '0) && !rsp_ch.saturated, "arrived band carries a nonzero result")
   `AS_ASSERT_IMPL(a_stall_needs_result, clock, reset, !pipe_en, rsp_ch.valid, "pipeline stalled with no result waiting")
   `AS_ASSERT_NEXT(a_stall_until_taken, clock, reset, !pipe_en && !rsp_ch.ready, !pipe_en, "pipeline resumed while both result slots were full")

endmodule
